// ===== rtl/core/ogts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid trait store package
// Grid dimensions, field widths, command and register codes, and the types
// shared by the controller, the datapath and the configuration registers.
// ----------------------------------------------------------------------------
package ogts_pkg;

	localparam int X_CELLS    = 64;
	localparam int Y_CELLS    = 64;
	localparam int Z_CELLS    = 4;
	localparam int TRAIT_BITS = 8;

	localparam int CELL_TOTAL = X_CELLS * Y_CELLS * Z_CELLS;
	localparam int ADDR_W     = $clog2(CELL_TOTAL);
	localparam int XI_W       = $clog2(X_CELLS);
	localparam int YI_W       = $clog2(Y_CELLS);
	localparam int ZI_W       = (Z_CELLS > 1) ? $clog2(Z_CELLS) : 1;
	localparam int ROW_W      = $clog2(Y_CELLS * Z_CELLS);
	localparam int CMP_W      = (TRAIT_BITS > 8) ? TRAIT_BITS : 8;

	localparam int COORD_W    = 9;
	localparam int CODE_W     = 8;
	localparam int CMD_W      = 3;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_GOAL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SCAN  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_X_SIZE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN  = 3'd7;

	typedef struct packed {
		logic [5:0]         x_size;
		logic [5:0]         y_size;
		logic [1:0]         z_size;
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [COORD_W-1:0] origin_z;
		logic [CODE_W-1:0]  goal_code;
		logic [CODE_W-1:0]  unknown_code;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic check;
		logic index;
		logic access;
		logic sweep_init;
		logic clear_wr;
		logic scan_rd;
		logic scan_end;
		logic clear_end;
	} ctrl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             sweep_last;
	} stat_t;

endpackage

// ===== rtl/core/ogts_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the grid bounds, origin offsets and special trait codes.
// ----------------------------------------------------------------------------
module ogts_cfg
	import ogts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_size       <= 6'd63;
			cfg_q.y_size       <= 6'd63;
			cfg_q.z_size       <= 2'd0;
			cfg_q.origin_x     <= '0;
			cfg_q.origin_y     <= '0;
			cfg_q.origin_z     <= '0;
			cfg_q.goal_code    <= 8'd4;
			cfg_q.unknown_code <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_SIZE:   cfg_q.x_size       <= cfg_data[5:0];
				REG_Y_SIZE:   cfg_q.y_size       <= cfg_data[5:0];
				REG_Z_SIZE:   cfg_q.z_size       <= cfg_data[1:0];
				REG_ORIGIN_X: cfg_q.origin_x     <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin_y     <= cfg_data;
				REG_ORIGIN_Z: cfg_q.origin_z     <= cfg_data;
				REG_GOAL:     cfg_q.goal_code    <= cfg_data[CODE_W-1:0];
				REG_UNKNOWN:  cfg_q.unknown_code <= cfg_data[CODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/ogts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command sequencer
// Steps each command through a check phase, then the index and access phases or a sweep phase.
// ----------------------------------------------------------------------------
module ogts_ctrl
	import ogts_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  busy,
	output logic  done
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_INDEX  = 4'd2;
	localparam logic [3:0] S_ACCESS = 4'd3;
	localparam logic [3:0] S_CLEAR  = 4'd4;
	localparam logic [3:0] S_SCAN   = 4'd5;
	localparam logic [3:0] S_TAIL   = 4'd6;
	localparam logic [3:0] S_FIN    = 4'd7;
	localparam logic [3:0] S_RESP   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctrl.capture = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				ctrl.check = 1'b1;
				if (stat.cmd inside {CMD_READ, CMD_WRITE, CMD_GOAL}) begin
					state_d = S_INDEX;
				end else if (stat.cmd == CMD_CLEAR) begin
					ctrl.sweep_init = 1'b1;
					state_d         = S_CLEAR;
				end else if (stat.cmd == CMD_SCAN) begin
					ctrl.sweep_init = 1'b1;
					state_d         = S_SCAN;
				end else begin
					state_d = S_RESP;
				end
			end
			S_INDEX: begin
				ctrl.index = 1'b1;
				state_d    = S_ACCESS;
			end
			S_ACCESS: begin
				ctrl.access = 1'b1;
				state_d     = S_RESP;
			end
			S_CLEAR: begin
				ctrl.clear_wr = 1'b1;
				if (stat.sweep_last) begin
					ctrl.clear_end = 1'b1;
					state_d        = S_RESP;
				end
			end
			S_SCAN: begin
				ctrl.scan_rd = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				ctrl.scan_end = 1'b1;
				state_d       = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

// ===== rtl/core/ogts_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid datapath
// Coordinate correction, bounds check, cell memory, sweep counters, scan
// compare and the latched goal position.
// ----------------------------------------------------------------------------
module ogts_dp
	import ogts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_t               ctrl,
	input  cfg_t                cfg,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [COORD_W-1:0]  x_coord,
	input  logic [COORD_W-1:0]  y_coord,
	input  logic [COORD_W-1:0]  z_coord,
	input  logic [CODE_W-1:0]   trait_in,
	output stat_t               stat,
	output logic [CODE_W-1:0]   trait_out,
	output logic                in_range,
	output logic                goal_valid,
	output logic [COORD_W-1:0]  goal_x,
	output logic [COORD_W-1:0]  goal_y,
	output logic [COORD_W-1:0]  goal_z
);

	// Captured command word.
	logic [CMD_W-1:0]      cmd_q;
	logic [COORD_W-1:0]    xi_q, yi_q, zi_q;
	logic [TRAIT_BITS-1:0] trait_q;

	// Address generation.
	logic                  ok_q;
	logic [XI_W-1:0]       cx_q;
	logic [ROW_W-1:0]      row_q;
	logic [ADDR_W-1:0]     idx_q;

	// Sweep counters.
	logic [XI_W-1:0]       sx_q;
	logic [YI_W-1:0]       sy_q;
	logic [ZI_W-1:0]       sz_q;
	logic [ADDR_W-1:0]     addr_q;

	// Cell memory.
	logic [TRAIT_BITS-1:0] cell_mem [CELL_TOTAL];
	logic [TRAIT_BITS-1:0] rd_q;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_addr;
	logic [TRAIT_BITS-1:0] mem_wd;

	// Scan compare stage.
	logic                  scan_v_s1;
	logic                  inb_s1;
	logic [XI_W-1:0]       sx_s1;
	logic [YI_W-1:0]       sy_s1;
	logic [ZI_W-1:0]       sz_s1;
	logic                  found_q;
	logic [COORD_W-1:0]    fx_q, fy_q, fz_q;

	// Goal.
	logic                  goal_flag_q;
	logic [COORD_W-1:0]    goal_x_q, goal_y_q, goal_z_q;

	logic [COORD_W-1:0]    xlim, ylim, zlim;
	logic [COORD_W:0]      cx_w, cy_w, cz_w;
	logic                  ok_w;
	logic [ROW_W:0]        row_w;
	logic [ADDR_W:0]       idx_w;
	logic                  inb_w;
	logic                  match_w;
	logic [CMP_W-1:0]      trait_wide, goal_wide, rd_wide;
	logic [TRAIT_BITS-1:0] goal_cell;
	logic [CMP_W-1:0]      goal_cell_wide;
	logic                  trait_is_goal;

	// A configured highest index beyond the store is limited to the last cell.
	assign xlim = (COORD_W'(cfg.x_size) >= COORD_W'(X_CELLS)) ?
		COORD_W'(X_CELLS - 1) : COORD_W'(cfg.x_size);
	assign ylim = (COORD_W'(cfg.y_size) >= COORD_W'(Y_CELLS)) ?
		COORD_W'(Y_CELLS - 1) : COORD_W'(cfg.y_size);
	assign zlim = (COORD_W'(cfg.z_size) >= COORD_W'(Z_CELLS)) ?
		COORD_W'(Z_CELLS - 1) : COORD_W'(cfg.z_size);

	assign cx_w = {xi_q[COORD_W-1], xi_q} + {cfg.origin_x[COORD_W-1], cfg.origin_x};
	assign cy_w = {yi_q[COORD_W-1], yi_q} + {cfg.origin_y[COORD_W-1], cfg.origin_y};
	assign cz_w = {zi_q[COORD_W-1], zi_q} + {cfg.origin_z[COORD_W-1], cfg.origin_z};

	assign ok_w = !cx_w[COORD_W] && (cx_w[COORD_W-1:0] <= xlim) &&
		!cy_w[COORD_W] && (cy_w[COORD_W-1:0] <= ylim) &&
		!cz_w[COORD_W] && (cz_w[COORD_W-1:0] <= zlim);

	assign row_w = (ROW_W + 1)'(cy_w[YI_W-1:0]) +
		(ROW_W + 1)'(Y_CELLS) * (ROW_W + 1)'(cz_w[ZI_W-1:0]);
	assign idx_w = (ADDR_W + 1)'(cx_q) + (ADDR_W + 1)'(X_CELLS) * (ADDR_W + 1)'(row_q);

	assign trait_wide     = CMP_W'(trait_in);
	assign goal_wide      = CMP_W'(cfg.goal_code);
	assign goal_cell      = goal_wide[TRAIT_BITS-1:0];
	assign goal_cell_wide = CMP_W'(goal_cell);
	assign rd_wide        = CMP_W'(rd_q);
	assign trait_is_goal  = (CMP_W'(trait_q) == goal_wide);

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q   <= cmd;
			xi_q    <= x_coord;
			yi_q    <= y_coord;
			zi_q    <= z_coord;
			trait_q <= trait_wide[TRAIT_BITS-1:0];
		end
		if (ctrl.check) begin
			ok_q  <= ok_w;
			cx_q  <= cx_w[XI_W-1:0];
			row_q <= row_w[ROW_W-1:0];
		end
		if (ctrl.index) begin
			idx_q <= idx_w[ADDR_W-1:0];
		end
	end

	// Sweep over every cell in index order, x fastest.
	always_ff @(posedge clk) begin
		if (ctrl.sweep_init) begin
			sx_q   <= '0;
			sy_q   <= '0;
			sz_q   <= '0;
			addr_q <= '0;
		end else if (ctrl.clear_wr || ctrl.scan_rd) begin
			addr_q <= addr_q + 1'b1;
			if (sx_q == XI_W'(X_CELLS - 1)) begin
				sx_q <= '0;
				if (sy_q == YI_W'(Y_CELLS - 1)) begin
					sy_q <= '0;
					sz_q <= sz_q + 1'b1;
				end else begin
					sy_q <= sy_q + 1'b1;
				end
			end else begin
				sx_q <= sx_q + 1'b1;
			end
		end
	end

	assign stat.cmd        = cmd_q;
	assign stat.sweep_last = (addr_q == ADDR_W'(CELL_TOTAL - 1));

	assign mem_we   = ctrl.clear_wr ||
		(ctrl.access && ok_q && (cmd_q == CMD_WRITE || cmd_q == CMD_GOAL));
	assign mem_addr = ctrl.access ? idx_q : addr_q;
	assign mem_wd   = (ctrl.access && cmd_q == CMD_GOAL) ? goal_cell : trait_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[mem_addr] <= mem_wd;
		end
		rd_q <= cell_mem[mem_addr];
	end

	assign inb_w = (COORD_W'(sx_q) <= xlim) && (COORD_W'(sy_q) <= ylim) &&
		(COORD_W'(sz_q) <= zlim);

	always_ff @(posedge clk) begin
		inb_s1 <= inb_w;
		sx_s1  <= sx_q;
		sy_s1  <= sy_q;
		sz_s1  <= sz_q;
	end

	assign match_w = scan_v_s1 && inb_s1 && (rd_wide == goal_wide);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			scan_v_s1 <= ctrl.scan_rd;
			if (ctrl.sweep_init) begin
				found_q <= 1'b0;
			end else if (match_w) begin
				found_q <= 1'b1;
			end
		end
	end

	// Later matches overwrite earlier ones, so the last cell in index order wins.
	always_ff @(posedge clk) begin
		if (match_w) begin
			fx_q <= COORD_W'(sx_s1) - cfg.origin_x;
			fy_q <= COORD_W'(sy_s1) - cfg.origin_y;
			fz_q <= COORD_W'(sz_s1) - cfg.origin_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_flag_q <= 1'b0;
			goal_x_q    <= '0;
			goal_y_q    <= '0;
			goal_z_q    <= '0;
		end else if (ctrl.access &&
			((cmd_q == CMD_GOAL) || (cmd_q == CMD_WRITE && ok_q && trait_is_goal))) begin
			goal_flag_q <= 1'b1;
			goal_x_q    <= xi_q;
			goal_y_q    <= yi_q;
			goal_z_q    <= zi_q;
		end else if (ctrl.scan_end && found_q) begin
			goal_flag_q <= 1'b1;
			goal_x_q    <= fx_q;
			goal_y_q    <= fy_q;
			goal_z_q    <= fz_q;
		end else if (ctrl.clear_end) begin
			goal_flag_q <= 1'b0;
		end
	end

	always_comb begin
		trait_out = '0;
		in_range  = 1'b0;
		case (cmd_q)
			CMD_READ: begin
				in_range  = ok_q;
				trait_out = ok_q ? rd_wide[CODE_W-1:0] : cfg.unknown_code;
			end
			CMD_WRITE: begin
				in_range  = ok_q;
				trait_out = ok_q ? CODE_W'(CMP_W'(trait_q)) : cfg.unknown_code;
			end
			CMD_GOAL: begin
				in_range  = ok_q;
				trait_out = ok_q ? goal_cell_wide[CODE_W-1:0] : cfg.unknown_code;
			end
			CMD_CLEAR: begin
				trait_out = CODE_W'(CMP_W'(trait_q));
			end
			CMD_SCAN: begin
				in_range  = found_q;
				trait_out = found_q ? cfg.goal_code : cfg.unknown_code;
			end
			default: begin
			end
		endcase
	end

	assign goal_valid = goal_flag_q;
	assign goal_x     = goal_flag_q ? goal_x_q : '0;
	assign goal_y     = goal_flag_q ? goal_y_q : '0;
	assign goal_z     = goal_flag_q ? goal_z_q : '0;

endmodule

// ===== rtl/core/occupancy_grid_trait_store.sv =====
`timescale 1ns / 1ps
// Read, write and set-goal pass through the check, index and access states before done;
// clear runs its sweep after the check, and scan its sweep, a tail and a finish state.
// Unused command codes go from the check state straight to done.
// One command word is handled at a time; the next can be taken from the cycle after done.
// The sweeps of clear and scan touch one cell per cycle through the single memory port.
// Reset clears the goal and the sequencer; the cells hold nothing until a clear.
// ----------------------------------------------------------------------------
// Occupancy grid trait store
// A three-dimensional grid of trait codes with origin correction, bounds
// checking, a latched goal position, a clearing sweep and a goal scan.
// ----------------------------------------------------------------------------
module occupancy_grid_trait_store
	import ogts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Command word.
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [COORD_W-1:0]   x_coord,
	input  logic [COORD_W-1:0]   y_coord,
	input  logic [COORD_W-1:0]   z_coord,
	input  logic [CODE_W-1:0]    trait_in,
	// Result word, valid for the single cycle in which done is high.
	output logic                 done,
	output logic [CODE_W-1:0]    trait_out,
	output logic                 in_range,
	output logic                 goal_valid,
	output logic [COORD_W-1:0]   goal_x,
	output logic [COORD_W-1:0]   goal_y,
	output logic [COORD_W-1:0]   goal_z,
	// Configuration writes.
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t  cfg;
	ctrl_t ctrl;
	stat_t stat;

	// The register bank holds bounds, origins and the goal and unknown codes.
	// Writes are expected only while the store is idle.
	ogts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The sequencer takes a command word when idle, walks it through the
	// bounds check, address build and memory access, or runs the full-grid
	// sweep for a clear or a scan, and then strobes done for one cycle.
	ogts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	// The datapath owns the cell memory and all arithmetic. The result ports
	// are decoded from its registers and are meaningful while done is high.
	ogts_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cfg        (cfg),
		.cmd        (cmd),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.z_coord    (z_coord),
		.trait_in   (trait_in),
		.stat       (stat),
		.trait_out  (trait_out),
		.in_range   (in_range),
		.goal_valid (goal_valid),
		.goal_x     (goal_x),
		.goal_y     (goal_y),
		.goal_z     (goal_z)
	);

endmodule
